// ===== rtl/core/cnuc_pkg.sv =====
// ----------------------------------------------------------------------------
// cnuc_pkg
// shared widths, constants and sequencer states for the column correction unit
// ----------------------------------------------------------------------------
package cnuc_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int WID_W      = COL_W + 1;
    localparam int PIX_W      = 16;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_W     = 24;
    localparam int SUM_W      = 28;
    localparam int TOTAL_W    = 38;
    localparam int DEN_W      = WID_W + SUM_W;
    localparam int NUM_W      = TOTAL_W + FRAC_BITS;
    localparam int REM_W      = NUM_W + 1;
    localparam int DSH_W      = DEN_W + GAIN_W - 1;
    localparam int PROD_W     = PIX_W + GAIN_W;
    localparam int QCNT_W     = $clog2(GAIN_W);

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << FRAC_BITS;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = {GAIN_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [WID_W-1:0]   WIDTH_RST = WID_W'(MAX_COLS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CAL_WR,
        S_COR_MUL,
        S_COR_RND,
        S_GP_RD,
        S_GP_MUL,
        S_GP_CHK,
        S_GP_WAIT,
        S_GP_WR
    } t_state;

endpackage

// ===== rtl/core/cnuc_ram.sv =====
// ----------------------------------------------------------------------------
// cnuc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cnuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cnuc_div.sv =====
// ----------------------------------------------------------------------------
// cnuc_div
// iterative restoring divider, one quotient bit a cycle, rounded and saturated
// ----------------------------------------------------------------------------
module cnuc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cnuc_pkg::NUM_W-1:0]  i_num,
    input  logic [cnuc_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [cnuc_pkg::GAIN_W-1:0] o_quot
);

    logic [cnuc_pkg::REM_W-1:0]  r_rem;
    logic [cnuc_pkg::DSH_W-1:0]  r_dsh;
    logic [cnuc_pkg::GAIN_W-1:0] r_q;
    logic [cnuc_pkg::QCNT_W-1:0] r_cnt;
    logic                        r_run;
    logic                        r_done;

    logic [cnuc_pkg::REM_W-1:0]  rem0;
    logic                        sat;
    logic                        ge;

    // numerator plus half the divisor gives round half up
    assign rem0 = {1'b0, i_num} + cnuc_pkg::REM_W'(i_den >> 1);
    // quotient would not fit the gain width
    assign sat  = ({(cnuc_pkg::DSH_W + 1)'(rem0)}) >= {i_den, {cnuc_pkg::GAIN_W{1'b0}}};
    assign ge   = cnuc_pkg::DSH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= rem0;
                r_dsh <= {i_den, {(cnuc_pkg::GAIN_W-1){1'b0}}};
                r_cnt <= cnuc_pkg::QCNT_W'(cnuc_pkg::GAIN_W - 1);
                if (sat) begin
                    r_q    <= cnuc_pkg::GAIN_MAX;
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh[cnuc_pkg::REM_W-1:0];
                end
                r_q   <= {r_q[cnuc_pkg::GAIN_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/column_nonuniformity_correction_unit.sv =====
// ----------------------------------------------------------------------------
// column_nonuniformity_correction_unit
// column flat-field gain calibration and per-pixel gain correction
// ----------------------------------------------------------------------------
// calibration word: accept, sum update, no result
// correction word: accept, multiply, round; result strobe registered after the round step
// last calibration word adds a pass over all 1024 columns: read, clear, check per column,
//   then divide and gain write inside the width in use (shorter for a zero or saturated gain)
// after reset a sweep over all columns clears the sums and sets gains to 1.0 with busy high;
//   config writes are taken at any time; results cannot be stalled by the receiver
module column_nonuniformity_correction_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_req_type,
    input  logic [15:0]                 i_pixel,
    input  logic [15:0]                 i_dark_level,
    input  logic [9:0]                  i_column,
    input  logic                        i_last_sample,
    output logic                        o_valid,
    output logic [15:0]                 o_corrected,
    output logic [9:0]                  o_out_column,
    output logic                        o_clipped,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [10:0]                 i_cfg_data
);

    cnuc_pkg::t_state r_state, n_state;

    // registered copy of the accepted word
    logic [cnuc_pkg::PIX_W-1:0]   r_pixel;
    logic [cnuc_pkg::PIX_W-1:0]   r_dark;
    logic [cnuc_pkg::COL_W-1:0]   r_column;
    logic                         r_last;

    logic [cnuc_pkg::WID_W-1:0]   r_width;
    logic [cnuc_pkg::TOTAL_W-1:0] r_total;
    logic [cnuc_pkg::COL_W-1:0]   r_col;     // sweep / gain pass column
    logic [cnuc_pkg::DEN_W-1:0]   r_den;
    logic                         r_zero;
    logic [cnuc_pkg::GAIN_W-1:0]  r_gain;
    logic [cnuc_pkg::PROD_W-1:0]  r_prod;

    logic                         r_valid;
    logic [cnuc_pkg::PIX_W-1:0]   r_corr;
    logic [cnuc_pkg::COL_W-1:0]   r_ocol;
    logic                         r_clip;

    // ram ports
    logic                         sum_we;
    logic [cnuc_pkg::SUM_W-1:0]   sum_wdata;
    logic [cnuc_pkg::COL_W-1:0]   sum_waddr;
    logic [cnuc_pkg::COL_W-1:0]   sum_raddr;
    logic [cnuc_pkg::SUM_W-1:0]   sum_rdata;
    logic                         gain_we;
    logic [cnuc_pkg::GAIN_W-1:0]  gain_wdata;
    logic [cnuc_pkg::GAIN_W-1:0]  gain_rdata;

    logic                         div_start;
    logic                         div_done;
    logic [cnuc_pkg::GAIN_W-1:0]  div_quot;

    logic                         accept;
    logic [cnuc_pkg::WID_W-1:0]   eff_w;
    logic                         cal_in_range;
    logic                         col_in_range;
    logic                         col_last;
    logic                         col_step;
    logic [cnuc_pkg::PIX_W-1:0]   diff;
    logic [cnuc_pkg::SUM_W:0]     sum_new;
    logic [cnuc_pkg::TOTAL_W:0]   tot_new;
    logic [cnuc_pkg::PROD_W:0]    rnd;

    assign accept = i_start && (r_state == cnuc_pkg::S_IDLE);
    assign o_busy = (r_state != cnuc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // width in use clamped to 1..MAX_COLS
    always_comb begin
        if (r_width == '0) begin
            eff_w = cnuc_pkg::WID_W'(1);
        end else if (r_width > cnuc_pkg::WIDTH_RST) begin
            eff_w = cnuc_pkg::WIDTH_RST;
        end else begin
            eff_w = r_width;
        end
    end

    assign cal_in_range = {1'b0, r_column} < eff_w;
    assign col_in_range = {1'b0, r_col} < eff_w;
    assign col_last     = (r_col == cnuc_pkg::COL_W'(cnuc_pkg::MAX_COLS - 1));

    // dark subtraction wraps, sums saturate
    assign diff    = r_pixel - r_dark;
    assign sum_new = {1'b0, sum_rdata} + (cnuc_pkg::SUM_W + 1)'(diff);
    assign tot_new = {1'b0, r_total} + (cnuc_pkg::TOTAL_W + 1)'(diff);

    // rounding of pixel times gain
    assign rnd = {1'b0, r_prod} + (cnuc_pkg::PROD_W + 1)'(1 << (cnuc_pkg::FRAC_BITS - 1));

    // sequencer
    always_comb begin
        n_state    = r_state;
        sum_we     = 1'b0;
        sum_waddr  = r_col;
        sum_wdata  = '0;
        gain_we    = 1'b0;
        gain_wdata = r_gain;
        div_start  = 1'b0;
        col_step   = 1'b0;
        sum_raddr  = (r_state == cnuc_pkg::S_IDLE) ? i_column : r_col;

        unique case (r_state)
            cnuc_pkg::S_INIT: begin
                sum_we     = 1'b1;
                gain_we    = 1'b1;
                gain_wdata = cnuc_pkg::GAIN_ONE;
                if (col_last) begin
                    n_state = cnuc_pkg::S_IDLE;
                end
            end
            cnuc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_req_type ? cnuc_pkg::S_COR_MUL : cnuc_pkg::S_CAL_WR;
                end
            end
            cnuc_pkg::S_CAL_WR: begin
                sum_we    = cal_in_range;
                sum_waddr = r_column;
                sum_wdata = sum_new[cnuc_pkg::SUM_W] ? cnuc_pkg::SUM_MAX
                                                     : sum_new[cnuc_pkg::SUM_W-1:0];
                n_state   = r_last ? cnuc_pkg::S_GP_RD : cnuc_pkg::S_IDLE;
            end
            cnuc_pkg::S_COR_MUL: begin
                n_state = cnuc_pkg::S_COR_RND;
            end
            cnuc_pkg::S_COR_RND: begin
                n_state = cnuc_pkg::S_IDLE;
            end
            cnuc_pkg::S_GP_RD: begin
                n_state = cnuc_pkg::S_GP_MUL;
            end
            cnuc_pkg::S_GP_MUL: begin
                // sum is read, clear it behind the read
                sum_we  = 1'b1;
                n_state = cnuc_pkg::S_GP_CHK;
            end
            cnuc_pkg::S_GP_CHK: begin
                if (!col_in_range) begin
                    col_step = 1'b1;
                end else if (r_zero) begin
                    n_state = cnuc_pkg::S_GP_WR;
                end else begin
                    div_start = 1'b1;
                    n_state   = cnuc_pkg::S_GP_WAIT;
                end
            end
            cnuc_pkg::S_GP_WAIT: begin
                if (div_done) begin
                    n_state = cnuc_pkg::S_GP_WR;
                end
            end
            cnuc_pkg::S_GP_WR: begin
                gain_we  = 1'b1;
                col_step = 1'b1;
            end
            default: begin
                n_state = cnuc_pkg::S_IDLE;
            end
        endcase

        if (col_step) begin
            n_state = col_last ? cnuc_pkg::S_IDLE : cnuc_pkg::S_GP_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cnuc_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= cnuc_pkg::WIDTH_RST;
            r_total <= '0;
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            r_valid <= (r_state == cnuc_pkg::S_COR_RND);
            if (r_state == cnuc_pkg::S_INIT || col_step) begin
                r_col <= r_col + 1'b1;
            end
            if (r_state == cnuc_pkg::S_CAL_WR) begin
                if (cal_in_range) begin
                    r_total <= tot_new[cnuc_pkg::TOTAL_W] ? cnuc_pkg::TOTAL_MAX
                                                          : tot_new[cnuc_pkg::TOTAL_W-1:0];
                end
                r_col <= '0;
            end
            if (col_step && col_last) begin
                r_total <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel  <= i_pixel;
            r_dark   <= i_dark_level;
            r_column <= i_column;
            r_last   <= i_last_sample;
        end
        if (r_state == cnuc_pkg::S_COR_MUL) begin
            r_prod <= cnuc_pkg::PROD_W'(r_pixel) * cnuc_pkg::PROD_W'(gain_rdata);
        end
        if (r_state == cnuc_pkg::S_COR_RND) begin
            r_ocol <= r_column;
            if (rnd[cnuc_pkg::PROD_W:cnuc_pkg::FRAC_BITS + cnuc_pkg::PIX_W] != '0) begin
                r_corr <= {cnuc_pkg::PIX_W{1'b1}};
                r_clip <= 1'b1;
            end else begin
                r_corr <= rnd[cnuc_pkg::FRAC_BITS +: cnuc_pkg::PIX_W];
                r_clip <= 1'b0;
            end
        end
        if (r_state == cnuc_pkg::S_GP_MUL) begin
            r_den  <= cnuc_pkg::DEN_W'(eff_w) * cnuc_pkg::DEN_W'(sum_rdata);
            r_zero <= (sum_rdata == '0);
        end
        if (r_state == cnuc_pkg::S_GP_CHK) begin
            r_gain <= cnuc_pkg::GAIN_MAX;
        end
        if (r_state == cnuc_pkg::S_GP_WAIT && div_done) begin
            r_gain <= div_quot;
        end
    end

    cnuc_ram #(
        .WIDTH (cnuc_pkg::SUM_W),
        .DEPTH (cnuc_pkg::MAX_COLS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    cnuc_ram #(
        .WIDTH (cnuc_pkg::GAIN_W),
        .DEPTH (cnuc_pkg::MAX_COLS)
    ) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (gain_we),
        .i_waddr (r_col),
        .i_wdata (gain_wdata),
        .i_raddr (i_column),
        .o_rdata (gain_rdata)
    );

    cnuc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_total, {cnuc_pkg::FRAC_BITS{1'b0}}}),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_valid      = r_valid;
    assign o_corrected  = r_corr;
    assign o_out_column = r_ocol;
    assign o_clipped    = r_clip;

    // a result strobe only follows the rounding step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == cnuc_pkg::S_COR_RND))
        else $error("result strobe without rounding step");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == cnuc_pkg::S_GP_WAIT))
        else $error("divider done outside wait state");

    // an accepted word makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks column gain calibration and pixel correction against a cycle-free
// predictor: calibration frames, gain passes and corrected pixels at random
// widths and with random start gaps
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic REQ_CAL = 1'b0;
    localparam logic REQ_COR = 1'b1;
    localparam int   WATCHDOG_LIMIT = 200000;
    localparam int   NUM_ITEMS = 1050;

    typedef struct packed {
        logic [15:0] corrected;
        logic [9:0]  column;
        logic        clipped;
    } t_pixel_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_req_type;
    logic [15:0] i_pixel;
    logic [15:0] i_dark_level;
    logic [9:0]  i_column;
    logic        i_last_sample;
    logic        o_valid;
    logic [15:0] o_corrected;
    logic [9:0]  o_out_column;
    logic        o_clipped;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;

    // predictor state
    logic [cnuc_pkg::SUM_W-1:0]   col_sum [cnuc_pkg::MAX_COLS];
    logic [cnuc_pkg::TOTAL_W-1:0] frame_sum;
    logic [cnuc_pkg::GAIN_W-1:0]  col_gain [cnuc_pkg::MAX_COLS];
    logic [10:0]                  width_reg;

    t_pixel_out pending_pixels [$];
    int         mismatches;
    int         items_sent;
    int         idle_cycles;

    column_nonuniformity_correction_unit u_top (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // effective width: zero counts as one, clamp to the column count
    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > cnuc_pkg::MAX_COLS) w = cnuc_pkg::MAX_COLS;
        return w;
    endfunction

    // recompute gains over the width in use, then clear all sums
    function automatic void run_gain_pass();
        int w;
        longint unsigned num, den, g;
        w = eff_width();
        for (int c = 0; c < w; c++) begin
            if (col_sum[c] == 0) begin
                col_gain[c] = cnuc_pkg::GAIN_MAX;
            end else begin
                num = longint'(frame_sum) << cnuc_pkg::FRAC_BITS;
                den = longint'(w) * longint'(col_sum[c]);
                g = (num + (den >> 1)) / den;
                col_gain[c] = (g > cnuc_pkg::GAIN_MAX) ? cnuc_pkg::GAIN_MAX
                                                       : g[cnuc_pkg::GAIN_W-1:0];
            end
        end
        for (int c = 0; c < cnuc_pkg::MAX_COLS; c++) col_sum[c] = '0;
        frame_sum = '0;
    endfunction

    // predict the effect of one accepted word
    function automatic void predict_word(logic req, logic [15:0] pix, logic [15:0] dark,
                                         logic [9:0] col, logic last);
        logic [15:0]                diff;
        logic [cnuc_pkg::SUM_W:0]   s;
        logic [cnuc_pkg::TOTAL_W:0] t;
        longint unsigned            prod, r;
        t_pixel_out                 o;
        if (req == REQ_CAL) begin
            if (int'(col) < eff_width()) begin
                diff = pix - dark;
                s = col_sum[col] + diff;
                t = frame_sum + diff;
                col_sum[col] = (s > cnuc_pkg::SUM_MAX) ? cnuc_pkg::SUM_MAX
                                                       : s[cnuc_pkg::SUM_W-1:0];
                frame_sum = (t > cnuc_pkg::TOTAL_MAX) ? cnuc_pkg::TOTAL_MAX
                                                      : t[cnuc_pkg::TOTAL_W-1:0];
            end
            if (last) run_gain_pass();
        end else begin
            prod = longint'(pix) * longint'(col_gain[col]);
            r = (prod + (64'd1 << (cnuc_pkg::FRAC_BITS - 1))) >> cnuc_pkg::FRAC_BITS;
            o.clipped = (r > 64'hFFFF);
            o.corrected = o.clipped ? 16'hFFFF : r[15:0];
            o.column = col;
            pending_pixels.push_back(o);
        end
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one word; start stays high after acceptance unless a gap follows
    task automatic send_word(logic req, logic [15:0] pix, logic [15:0] dark,
                             logic [9:0] col, logic last, int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_req_type    <= req;
        i_pixel       <= pix;
        i_dark_level  <= dark;
        i_column      <= col;
        i_last_sample <= last;
        do @(posedge i_clk); while (o_busy);
        predict_word(req, pix, dark, col, last);
        items_sent++;
    endtask

    // drain results and any gain pass, then write the width register
    task automatic write_width(logic [10:0] value);
        i_start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        width_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: corrected=%0d column=%0d clipped=%0d",
                             o_corrected, o_out_column, o_clipped);
            end else begin
                want = pending_pixels.pop_front();
                if (o_corrected !== want.corrected || o_out_column !== want.column ||
                    o_clipped !== want.clipped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.corrected, want.column, want.clipped,
                                 o_corrected, o_out_column, o_clipped);
                end
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("column_nonuniformity_correction_unit test failed");
            $finish;
        end
    end

    // gains after reset are 1.0, extremes of pixel and column
    task automatic test_reset_gains();
        send_word(REQ_COR, 16'h0000, 16'h0000, 10'd0, 1'b0, 0);
        send_word(REQ_COR, 16'hFFFF, 16'h0000, 10'd1023, 1'b1, 0);
        send_word(REQ_COR, 16'h8001, 16'hFFFF, 10'd512, 1'b0, 2);
    endtask

    // dark wrap, out-of-range column with last mark, zero sums, clipping
    task automatic test_calibration_edges();
        write_width(11'd4);
        send_word(REQ_CAL, 16'd100, 16'd200, 10'd0, 1'b0, 0);   // wraps below zero
        send_word(REQ_CAL, 16'hFFFF, 16'h0000, 10'd1, 1'b0, 0);
        send_word(REQ_CAL, 16'd10, 16'd10, 10'd2, 1'b0, 1);     // zero difference
        send_word(REQ_CAL, 16'd500, 16'd0, 10'd9, 1'b1, 0);     // ignored column, still ends
        for (int c = 0; c < 6; c++)
            send_word(REQ_COR, 16'(16'hFFFF - c), 16'h0, 10'(c), 1'b0, c % 2);
        send_word(REQ_COR, 16'd1, 16'h0, 10'd1, 1'b0, 0);
        // width zero behaves as one column
        write_width(11'd0);
        send_word(REQ_CAL, 16'd300, 16'd44, 10'd0, 1'b0, 0);
        send_word(REQ_CAL, 16'd7, 16'd3, 10'd1, 1'b1, 0);
        send_word(REQ_COR, 16'd1234, 16'h0, 10'd0, 1'b0, 0);
        send_word(REQ_COR, 16'd1234, 16'h0, 10'd1, 1'b0, 0);
        // oversized width clamps to full width; pass over every column
        write_width(11'h7FF);
        send_word(REQ_CAL, 16'd9000, 16'd1000, 10'd1023, 1'b0, 0);
        send_word(REQ_CAL, 16'd100, 16'd0, 10'd3, 1'b1, 0);
        send_word(REQ_COR, 16'd40000, 16'h0, 10'd1023, 1'b0, 0);
        send_word(REQ_COR, 16'd3, 16'h0, 10'd3, 1'b0, 0);
        send_word(REQ_COR, 16'd3, 16'h0, 10'd5, 1'b0, 0);
    endtask

    // one large column sum against a small one, the small one saturates its gain
    task automatic test_large_sum();
        write_width(11'd2);
        for (int i = 0; i < 400; i++)
            send_word(REQ_CAL, 16'hFFFF, 16'h0000, 10'd0, 1'b0, 0);
        send_word(REQ_CAL, 16'd50, 16'd0, 10'd1, 1'b1, 0);
        send_word(REQ_COR, 16'hFFFF, 16'h0, 10'd0, 1'b0, 0);
        send_word(REQ_COR, 16'hFFFF, 16'h0, 10'd1, 1'b0, 0);
    endtask

    // random calibration frames followed by correction bursts
    task automatic test_random_frames();
        int w, n_cal, n_cor, frame;
        logic [15:0] pix, dark;
        logic [9:0]  col;
        frame = 0;
        while (items_sent < NUM_ITEMS) begin
            if (frame == 6) w = 1024;
            else if (frame == 9) w = 1365;
            else if (frame == 12) w = 682;
            else w = $urandom_range(1, 40);
            write_width(11'(w));
            w = eff_width();
            n_cal = $urandom_range(10, 60);
            for (int i = 0; i < n_cal; i++) begin
                pix  = 16'($urandom);
                dark = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'(pix - $urandom_range(0, 900));
                col  = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, w - 1));
                send_word(REQ_CAL, pix, dark, col, 1'b0, pick_gap());
            end
            send_word(REQ_CAL, 16'($urandom), 16'($urandom), 10'($urandom_range(0, w - 1)),
                      1'b1, pick_gap());
            n_cor = $urandom_range(20, 60);
            for (int i = 0; i < n_cor; i++) begin
                col = ($urandom_range(0, 9) == 0) ? 10'($urandom) :
                      10'($urandom_range(0, (w < 1023) ? w : 1023));
                send_word(REQ_COR, 16'($urandom), 16'($urandom), col, 1'($urandom),
                          pick_gap());
            end
            frame++;
        end
    endtask

    initial begin
        mismatches    = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        width_reg     = 11'(cnuc_pkg::MAX_COLS);
        frame_sum     = '0;
        for (int c = 0; c < cnuc_pkg::MAX_COLS; c++) begin
            col_sum[c]  = '0;
            col_gain[c] = cnuc_pkg::GAIN_ONE;
        end
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_req_type    = 1'b0;
        i_pixel       = '0;
        i_dark_level  = '0;
        i_column      = '0;
        i_last_sample = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_gains();
        test_calibration_edges();
        test_large_sum();
        test_random_frames();

        // drain outstanding results
        i_start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("column_nonuniformity_correction_unit test passed");
        else
            $display("column_nonuniformity_correction_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cnuc_pkg.sv
rtl/core/cnuc_ram.sv
rtl/core/cnuc_div.sv
rtl/core/column_nonuniformity_correction_unit.sv
test/tb_top.sv
